// ----- rtl/ptw_pkg.sv -----
// Page table walker package: widths, result kinds, beat structs and
// the entry index and canonical address helpers. No dependencies.
`default_nettype none

package ptw_pkg;

  localparam int unsigned LEVELS_DEF  = 4;
  localparam int unsigned INDEX_BITS  = 9;
  localparam int unsigned PAGE_SHIFT  = 12;
  localparam int unsigned VA_W        = 48;
  localparam int unsigned PA_W        = 64;
  localparam int unsigned ENTRY_W     = 64;
  localparam int unsigned LEVEL_W     = 3;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned FRAME_W     = VA_W - PAGE_SHIFT;
  localparam int unsigned ENTRY_SHIFT = 3;
  localparam int unsigned PRESENT_BIT = 0;
  localparam int unsigned PS_BIT      = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ  = 2'd0,
    KIND_LEAF  = 2'd1,
    KIND_FAULT = 2'd2,
    KIND_PROTO = 2'd3
  } ptw_kind_e;

  typedef struct packed {
    logic               func;
    logic [VA_W-1:0]    virt_addr;
    logic [ENTRY_W-1:0] entry_data;
  } ptw_item_t;

  typedef struct packed {
    ptw_kind_e          kind;
    logic [PA_W-1:0]    mem_addr;
    logic [ENTRY_W-1:0] leaf_entry;
    logic [LEVEL_W-1:0] walk_level;
  } ptw_result_t;

  function automatic logic [PA_W-1:0] ptw_canon(input logic [VA_W-1:0] a);
    ptw_canon = {{(PA_W - VA_W){a[VA_W-1]}}, a};
  endfunction

  function automatic logic [INDEX_BITS-1:0] ptw_index(input logic [VA_W-1:0]    va,
                                                      input logic [LEVEL_W-1:0] lvl);
    logic [INDEX_BITS-1:0] idx;
    idx = '0;
    for (int l = 1; l <= int'((VA_W - PAGE_SHIFT) / INDEX_BITS); l++) begin
      if (lvl == LEVEL_W'(l)) begin
        idx = va[PAGE_SHIFT + (l - 1) * INDEX_BITS +: INDEX_BITS];
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ptw_req_if.sv -----
// Request channel of the page table walker: valid/ready and the input beat.
// Depends on ptw_pkg.
`default_nettype none

interface ptw_req_if
  import ptw_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               func;
  logic [VA_W-1:0]    virt_addr;
  logic [ENTRY_W-1:0] entry_data;

  modport source (output valid, func, virt_addr, entry_data, input ready);
  modport sink   (input valid, func, virt_addr, entry_data, output ready);
endinterface

`default_nettype wire

// ----- rtl/ptw_rsp_if.sv -----
// Result channel of the page table walker: valid/ready and the result beat.
// Depends on ptw_pkg.
`default_nettype none

interface ptw_rsp_if
  import ptw_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [PA_W-1:0]    mem_addr;
  logic [ENTRY_W-1:0] leaf_entry;
  logic [LEVEL_W-1:0] walk_level;

  modport source (output valid, kind, mem_addr, leaf_entry, walk_level, input ready);
  modport sink   (input valid, kind, mem_addr, leaf_entry, walk_level, output ready);
endinterface

`default_nettype wire

// ----- rtl/ptw_in_stage.sv -----
// Input register of the page table walker: captures one request beat.
// Depends on ptw_pkg and ptw_req_if.
`default_nettype none

module ptw_in_stage
  import ptw_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ptw_req_if.sink    req,
  input  wire logic  take_i,
  output logic       valid_o,
  output ptw_item_t  item_o
);

  logic      valid_q, valid_d;
  logic      accept;
  ptw_item_t item_q;

  assign req.ready = !valid_q || take_i;
  assign accept    = req.valid && req.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.func       <= req.func;
      item_q.virt_addr  <= req.virt_addr;
      item_q.entry_data <= req.entry_data;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ----- rtl/ptw_walk.sv -----
// Walk state and single-pass step logic: root base, level, pending address.
// Depends on ptw_pkg.
`default_nettype none

module ptw_walk
  import ptw_pkg::*;
#(
  parameter int unsigned LEVELS = LEVELS_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [VA_W-1:0] cfg_wdata_i,
  input  wire logic            take_i,
  input  wire ptw_item_t       item_i,
  output ptw_result_t          res_o
);

  logic [FRAME_W-1:0] root_frame_q;
  logic               busy_q, busy_d;
  logic [LEVEL_W-1:0] level_q, level_d;
  logic [VA_W-1:0]    vaddr_q, vaddr_d;
  logic [VA_W-1:0]    eaddr_q, eaddr_d;

  logic               issue;
  logic [VA_W-1:0]    rd_va;
  logic [FRAME_W-1:0] rd_frame;
  logic [LEVEL_W-1:0] rd_level;
  logic [VA_W-1:0]    rd_addr;
  logic               is_leaf;

  assign rd_addr = {rd_frame, ptw_index(rd_va, rd_level), ENTRY_SHIFT'(0)};
  assign is_leaf = (level_q <= LEVEL_W'(1)) ||
                   (level_q == LEVEL_W'(2) && item_i.entry_data[PS_BIT]);

  always_comb begin
    busy_d   = busy_q;
    level_d  = level_q;
    vaddr_d  = vaddr_q;
    eaddr_d  = eaddr_q;
    issue    = 1'b0;
    rd_va    = vaddr_q;
    rd_frame = item_i.entry_data[VA_W-1:PAGE_SHIFT];
    rd_level = LEVEL_W'(level_q - LEVEL_W'(1));
    res_o.kind       = KIND_PROTO;
    res_o.mem_addr   = '0;
    res_o.leaf_entry = '0;
    res_o.walk_level = level_q;

    if (!item_i.func) begin
      if (!busy_q) begin
        issue    = 1'b1;
        rd_va    = item_i.virt_addr;
        rd_frame = root_frame_q;
        rd_level = LEVEL_W'(LEVELS);
      end
    end else if (busy_q) begin
      if (!item_i.entry_data[PRESENT_BIT]) begin
        res_o.kind     = KIND_FAULT;
        res_o.mem_addr = ptw_canon(eaddr_q);
        busy_d         = 1'b0;
        level_d        = LEVEL_W'(LEVELS);
      end else if (is_leaf) begin
        res_o.kind       = KIND_LEAF;
        res_o.mem_addr   = ptw_canon(eaddr_q);
        res_o.leaf_entry = item_i.entry_data;
        busy_d           = 1'b0;
        level_d          = LEVEL_W'(LEVELS);
      end else begin
        issue = 1'b1;
      end
    end

    if (issue) begin
      res_o.kind       = KIND_READ;
      res_o.mem_addr   = ptw_canon(rd_addr);
      res_o.walk_level = rd_level;
      busy_d           = 1'b1;
      level_d          = rd_level;
      vaddr_d          = rd_va;
      eaddr_d          = rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_frame_q <= '0;
      busy_q       <= 1'b0;
      level_q      <= LEVEL_W'(LEVELS);
      vaddr_q      <= '0;
      eaddr_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        root_frame_q <= cfg_wdata_i[VA_W-1:PAGE_SHIFT];
      end
      if (take_i) begin
        busy_q  <= busy_d;
        level_q <= level_d;
        vaddr_q <= vaddr_d;
        eaddr_q <= eaddr_d;
      end
    end
  end

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q >= LEVEL_W'(1) && level_q <= LEVEL_W'(LEVELS))
    else $error("walk level out of range");

  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && (res_o.kind == KIND_LEAF || res_o.kind == KIND_FAULT)
      |=> !busy_q && level_q == LEVEL_W'(LEVELS))
    else $error("walk did not end after leaf or fault");

  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && res_o.kind == KIND_READ |=> busy_q && level_q == $past(res_o.walk_level))
    else $error("read request without walk in progress");

  a_proto_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && res_o.kind == KIND_PROTO |=> $stable(busy_q) && $stable(eaddr_q))
    else $error("protocol error changed walk state");

endmodule

`default_nettype wire

// ----- rtl/ptw_out_stage.sv -----
// Result register of the page table walker: holds one result beat.
// Depends on ptw_pkg and ptw_rsp_if.
`default_nettype none

module ptw_out_stage
  import ptw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        res_valid_i,
  input  wire ptw_result_t res_i,
  output logic             take_o,
  ptw_rsp_if.source        rsp
);

  logic        valid_q, valid_d;
  ptw_result_t res_q;

  assign take_o = res_valid_i && (!valid_q || rsp.ready);

  always_comb begin
    valid_d = valid_q;
    if (take_o) begin
      valid_d = 1'b1;
    end else if (rsp.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      res_q <= res_i;
    end
  end

  assign rsp.valid      = valid_q;
  assign rsp.kind       = res_q.kind;
  assign rsp.mem_addr   = res_q.mem_addr;
  assign rsp.leaf_entry = res_q.leaf_entry;
  assign rsp.walk_level = res_q.walk_level;

endmodule

`default_nettype wire

// ----- rtl/page_table_walker.sv -----
// Page table walker top: one request beat in, one result beat out per cycle while rsp.ready.
// Request held in the input register, its result in the output register when that is free.
// Throughput: 1 beat per cycle while rsp.ready is high; the step logic is combinational.
// Reset: asynchronous active low; walker idle, level at top, root base zero.
// Depends on ptw_pkg, ptw_req_if, ptw_rsp_if, ptw_in_stage, ptw_walk, ptw_out_stage.
`default_nettype none

module page_table_walker
  import ptw_pkg::*;
#(
  parameter int unsigned LEVELS = LEVELS_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [VA_W-1:0] cfg_wdata_i,
  ptw_req_if.sink              req,
  ptw_rsp_if.source            rsp
);

  logic        item_valid;
  ptw_item_t   item;
  ptw_result_t res;
  logic        take;

  ptw_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req),
    .take_i  (take),
    .valid_o (item_valid),
    .item_o  (item)
  );

  ptw_walk #(
    .LEVELS (LEVELS)
  ) u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .item_i      (item),
    .res_o       (res)
  );

  ptw_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (item_valid),
    .res_i       (res),
    .take_o      (take),
    .rsp         (rsp)
  );

endmodule

`default_nettype wire
